@@ rtl/pfsd_pkg.sv @@
package pfsd_pkg;

  // operation codes
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_HSPAN = 2'd1;
  localparam logic [1:0] OP_VSPAN = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // draw modes; the unused code behaves like set
  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;

  localparam logic [7:0] FULL_MASK = 8'hFF;
  localparam int unsigned ADDR_W   = 12;  // holds the largest buffer (256 x 16 pages)

  typedef enum logic [1:0] {
    K_NOP,
    K_READ,
    K_DRAW
  } kind_e;

  // one classified request, as queued between front and back
  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] base;
    logic              step_page;  // 1: next byte is one page down, 0: next column
    logic [7:0]        cnt;        // bytes to touch minus one
    logic [7:0]        mid;
    logic [7:0]        first;
    logic [7:0]        last;
    logic [1:0]        mode;
    logic              drew;
    logic              region_valid;
    logic [6:0]        col_first;
    logic [6:0]        col_last;
    logic [5:0]        row_first;
    logic [5:0]        row_last;
  } job_t;

  function automatic logic [7:0] apply_mask(input logic [7:0] data, input logic [7:0] mask,
                                            input logic [1:0] mode);
    logic [7:0] res;
    case (mode)
      MODE_CLEAR:  res = data & ~mask;
      MODE_INVERT: res = data ^ mask;
      default:     res = data | mask;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/pfsd_front.sv @@
module pfsd_front #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic              start,
  input  logic              q_full_i,
  input  logic              clearing_i,
  input  logic [1:0]        operation_i,
  input  logic signed [9:0] pos_x_i,
  input  logic signed [9:0] pos_y_i,
  input  logic [7:0]        span_length_i,
  input  logic [1:0]        draw_mode_i,
  input  logic [9:0]        byte_address_i,
  input  logic              report_region_i,
  output logic              busy_o,
  output logic              push_o,
  output pfsd_pkg::job_t    job_o
);
  import pfsd_pkg::*;

  localparam int unsigned PAGES    = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned FB_BYTES = SCREEN_WIDTH * PAGES;
  localparam logic signed [10:0] W_S = 11'(SCREEN_WIDTH);
  localparam logic signed [10:0] H_S = 11'(SCREEN_HEIGHT);

  logic signed [10:0] xs, ys, len_s, x_end, y_end;
  logic signed [10:0] h_a, h_b, v_a, v_b;
  logic               x_on, y_on, h_ok, v_ok, rd_ok;
  logic [3:0]         y_page, va_page, vb_page;
  logic [12:0]        h_base, v_base;

  assign busy_o = clearing_i | q_full_i;
  assign push_o = start & ~busy_o;

  assign xs    = {pos_x_i[9], pos_x_i};
  assign ys    = {pos_y_i[9], pos_y_i};
  assign len_s = $signed({3'b000, span_length_i});
  assign x_end = xs + len_s - 11'sd1;
  assign y_end = ys + len_s - 11'sd1;

  assign x_on = (xs >= 11'sd0) && (xs < W_S);
  assign y_on = (ys >= 11'sd0) && (ys < H_S);

  // clip both span ranges to the screen
  assign h_a  = (xs < 11'sd0) ? 11'sd0 : xs;
  assign h_b  = (x_end > W_S - 11'sd1) ? W_S - 11'sd1 : x_end;
  assign h_ok = (span_length_i != 8'd0) && (h_b >= h_a);
  assign v_a  = (ys < 11'sd0) ? 11'sd0 : ys;
  assign v_b  = (y_end > H_S - 11'sd1) ? H_S - 11'sd1 : y_end;
  assign v_ok = (span_length_i != 8'd0) && (v_b >= v_a);

  assign y_page  = ys[6:3];
  assign va_page = v_a[6:3];
  assign vb_page = v_b[6:3];

  // page * width is a small constant multiply
  assign h_base = 13'(y_page) * 13'(SCREEN_WIDTH) + 13'(h_a[7:0]);
  assign v_base = 13'(va_page) * 13'(SCREEN_WIDTH) + 13'(xs[7:0]);

  assign rd_ok = 13'(byte_address_i) < 13'(FB_BYTES);

  always_comb begin
    job_o           = '0;
    job_o.kind      = K_NOP;
    job_o.mode      = draw_mode_i;
    job_o.first     = FULL_MASK;
    job_o.last      = FULL_MASK;
    job_o.mid       = FULL_MASK;
    case (operation_i)
      OP_READ: begin
        if (rd_ok) begin
          job_o.kind = K_READ;
          job_o.base = ADDR_W'(byte_address_i);
        end
      end
      OP_PIXEL: begin
        if (x_on && y_on) begin
          job_o.kind      = K_DRAW;
          job_o.base      = ADDR_W'(h_base);
          job_o.mid       = 8'd1 << ys[2:0];
          job_o.drew      = 1'b1;
          job_o.col_first = xs[6:0];
          job_o.col_last  = xs[6:0];
          job_o.row_first = ys[5:0];
          job_o.row_last  = ys[5:0];
        end
      end
      OP_HSPAN: begin
        if (y_on && h_ok) begin
          job_o.kind      = K_DRAW;
          job_o.base      = ADDR_W'(h_base);
          job_o.cnt       = 8'(h_b - h_a);
          job_o.mid       = 8'd1 << ys[2:0];
          job_o.drew      = 1'b1;
          job_o.col_first = h_a[6:0];
          job_o.col_last  = h_b[6:0];
          job_o.row_first = ys[5:0];
          job_o.row_last  = ys[5:0];
        end
      end
      default: begin  // vertical span
        if (x_on && v_ok) begin
          job_o.kind      = K_DRAW;
          job_o.base      = ADDR_W'(v_base);
          job_o.step_page = 1'b1;
          job_o.cnt       = {4'b0000, vb_page} - {4'b0000, va_page};
          job_o.first     = FULL_MASK << v_a[2:0];
          job_o.last      = FULL_MASK >> (3'd7 - v_b[2:0]);
          job_o.drew      = 1'b1;
          job_o.col_first = xs[6:0];
          job_o.col_last  = xs[6:0];
          job_o.row_first = v_a[5:0];
          job_o.row_last  = v_b[5:0];
        end
      end
    endcase
    job_o.region_valid = job_o.drew & report_region_i;
    if (!job_o.region_valid) begin
      job_o.col_first = '0;
      job_o.col_last  = '0;
      job_o.row_first = '0;
      job_o.row_last  = '0;
    end
  end

endmodule

@@ rtl/pfsd_queue.sv @@
module pfsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pfsd_pkg::job_t job_i,
  input  logic           pop_i,
  output pfsd_pkg::job_t job_o,
  output logic           full_o,
  output logic           empty_o
);
  import pfsd_pkg::*;

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign job_o   = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ rtl/pfsd_back.sv @@
module pfsd_back #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pfsd_pkg::job_t q_job_i,
  input  logic           q_empty_i,
  output logic           pop_o,
  output logic           clearing_o,
  output logic           done_o,
  output logic [7:0]     read_data_o,
  output logic           drew_any_o,
  output logic           region_valid_o,
  output logic [6:0]     col_first_o,
  output logic [6:0]     col_last_o,
  output logic [5:0]     row_first_o,
  output logic [5:0]     row_last_o
);
  import pfsd_pkg::*;

  localparam int unsigned PAGES    = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned FB_BYTES = SCREEN_WIDTH * PAGES;
  localparam int unsigned AW       = $clog2(FB_BYTES);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_e;

  state_e            state_q;
  job_t              job_q;
  logic [ADDR_W-1:0] addr_q, wr_addr_q, addr_step;
  logic [7:0]        k_q, cur_mask, wr_mask_q;
  logic              wr_vld_q;
  logic [7:0]        mem [FB_BYTES];
  logic [7:0]        rd_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  assign pop_o      = (state_q == S_IDLE) && !q_empty_i;
  assign clearing_o = state_q == S_CLEAR;

  assign addr_step = job_q.step_page ? ADDR_W'(SCREEN_WIDTH) : ADDR_W'(1);
  assign cur_mask  = job_q.mid & ((k_q == 8'd0) ? job_q.first : FULL_MASK)
                               & ((k_q == job_q.cnt) ? job_q.last : FULL_MASK);

  // write port: clearing sweep, or the modify half of a read-modify-write
  assign mem_we    = clearing_o | wr_vld_q;
  assign mem_waddr = clearing_o ? addr_q : wr_addr_q;
  assign mem_wdata = clearing_o ? 8'h00 : apply_mask(rd_q, wr_mask_q, job_q.mode);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr[AW-1:0]] <= mem_wdata;
    end
    rd_q <= mem[addr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      job_q          <= '0;
      addr_q         <= '0;
      k_q            <= '0;
      wr_vld_q       <= 1'b0;
      wr_addr_q      <= '0;
      wr_mask_q      <= '0;
      done_o         <= 1'b0;
      read_data_o    <= '0;
      drew_any_o     <= 1'b0;
      region_valid_o <= 1'b0;
      col_first_o    <= '0;
      col_last_o     <= '0;
      row_first_o    <= '0;
      row_last_o     <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (addr_q == ADDR_W'(FB_BYTES - 1)) begin
            addr_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            addr_q <= addr_q + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (!q_empty_i) begin
            job_q  <= q_job_i;
            addr_q <= q_job_i.base;
            k_q    <= '0;
            if (q_job_i.kind == K_NOP) begin
              done_o         <= 1'b1;
              read_data_o    <= '0;
              drew_any_o     <= q_job_i.drew;
              region_valid_o <= q_job_i.region_valid;
              col_first_o    <= q_job_i.col_first;
              col_last_o     <= q_job_i.col_last;
              row_first_o    <= q_job_i.row_first;
              row_last_o     <= q_job_i.row_last;
            end else begin
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          wr_vld_q  <= job_q.kind == K_DRAW;
          wr_addr_q <= addr_q;
          wr_mask_q <= cur_mask;
          if (k_q == job_q.cnt) begin
            state_q <= S_DRAIN;
          end else begin
            addr_q <= addr_q + addr_step;
            k_q    <= k_q + 8'd1;
          end
        end
        S_DRAIN: begin
          wr_vld_q       <= 1'b0;
          done_o         <= 1'b1;
          read_data_o    <= (job_q.kind == K_READ) ? rd_q : 8'h00;
          drew_any_o     <= job_q.drew;
          region_valid_o <= job_q.region_valid;
          col_first_o    <= job_q.col_first;
          col_last_o     <= job_q.col_last;
          row_first_o    <= job_q.row_first;
          row_last_o     <= job_q.row_last;
          state_q        <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_region_implies_drew: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && region_valid_o |-> drew_any_o)
    else $error("region reported without a draw");

  a_read_no_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (read_data_o != 8'h00) |-> !drew_any_o)
    else $error("read data on a draw result");

  a_write_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_vld_q |-> $past(state_q == S_RUN))
    else $error("buffer write without a preceding read");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> k_q <= job_q.cnt)
    else $error("byte counter ran past the span");

endmodule

@@ rtl/page_framebuffer_span_draw.sv @@
// Flow: a request accepted when idle passes through the job queue, a dispatch step in the
//   idle state, a read-modify-write step for each buffer byte, a drain step, then the done strobe.
// The back end touches one buffer byte per cycle; a request with nothing left after clipping
//   is answered straight from the idle state. No receiver stall. New requests are taken while
//   a span runs, until the two-entry queue is full.
// Reset: async, active low. Afterwards busy stays high while the buffer is swept to zero.
module page_framebuffer_span_draw #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request side
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation_i,
  input  logic signed [9:0] pos_x_i,
  input  logic signed [9:0] pos_y_i,
  input  logic [7:0]        span_length_i,
  input  logic [1:0]        draw_mode_i,
  input  logic [9:0]        byte_address_i,
  input  logic              report_region_i,
  // result side, one strobe per request
  output logic              done_o,
  output logic [7:0]        read_data_o,
  output logic              drew_any_o,
  output logic              region_valid_o,
  output logic [6:0]        col_first_o,
  output logic [6:0]        col_last_o,
  output logic [5:0]        row_first_o,
  output logic [5:0]        row_last_o
);
  import pfsd_pkg::*;

  job_t front_job, q_job;
  logic push, pop, q_full, q_empty, clearing;

  // Front: clips the request to the screen and turns it into a byte job:
  // start address, stride (column or page), byte count and the three masks.
  pfsd_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .start          (start),
    .q_full_i       (q_full),
    .clearing_i     (clearing),
    .operation_i    (operation_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .span_length_i  (span_length_i),
    .draw_mode_i    (draw_mode_i),
    .byte_address_i (byte_address_i),
    .report_region_i(report_region_i),
    .busy_o         (busy),
    .push_o         (push),
    .job_o          (front_job)
  );

  // Two-entry job queue so new requests are taken while a long span runs.
  pfsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .pop_i  (pop),
    .job_o  (q_job),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // Back: owns the frame buffer, runs the reset clear sweep and the
  // per-byte read-modify-write loop, then registers the result.
  pfsd_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_job_i       (q_job),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .done_o        (done_o),
    .read_data_o   (read_data_o),
    .drew_any_o    (drew_any_o),
    .region_valid_o(region_valid_o),
    .col_first_o   (col_first_o),
    .col_last_o    (col_last_o),
    .row_first_o   (row_first_o),
    .row_last_o    (row_last_o)
  );

endmodule
